// ===== hdl/fcbb_pkg.sv =====
// Shared constants, types and helpers for the frame change bounding box block.
// No dependencies.
`default_nettype none
package fcbb_pkg;

  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int PIX_W   = 8;
  localparam int DIM_W   = 10;
  localparam int COORD_W = 9;
  localparam int DELAY_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY    = 2'd2;

  localparam logic [DIM_W-1:0] WIDTH_TOP  = DIM_W'(MAX_WIDTH & ~1);
  localparam logic [DIM_W-1:0] HEIGHT_TOP = DIM_W'(MAX_HEIGHT & ~1);
  localparam logic [DIM_W-1:0] DIM_FLOOR  = DIM_W'(2);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } item_t;

  typedef struct packed {
    logic               changed;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_y;
    logic [DELAY_W-1:0] delay;
    logic               first;
  } result_t;

  function automatic logic [DIM_W-1:0] dim_in_use(input logic [DIM_W-1:0] value,
                                                  input logic [DIM_W-1:0] top);
    logic [DIM_W-1:0] v;
    v = value & ~DIM_W'(1);
    if (v < DIM_FLOOR) v = DIM_FLOOR;
    if (v > top) v = top;
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fcbb_frame_store.sv =====
// Previous frame store: one write port, one registered read port.
// Depends on fcbb_pkg.
`default_nettype none
module fcbb_frame_store
  import fcbb_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [PIX_W-1:0]  rd_data,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [PIX_W-1:0]  wr_data
);

  logic [PIX_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fcbb_box_track.sv =====
// Compare stage: pixel against stored pixel, bounding box, delay and frame result.
// Depends on fcbb_pkg.
`default_nettype none
module fcbb_box_track
  import fcbb_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire item_t              item,
  input  wire logic [PIX_W-1:0]   stored,
  input  wire logic [COORD_W-1:0] last_x,
  input  wire logic [COORD_W-1:0] last_y,
  input  wire logic [DELAY_W-1:0] max_delay,
  output logic                    res_valid,
  output result_t                 res
);

  logic               have_previous;
  logic               any_change;
  logic [COL_W-1:0]   box_min_x;
  logic [COL_W-1:0]   box_max_x;
  logic [ROW_W-1:0]   box_min_y;
  logic [ROW_W-1:0]   box_max_y;
  logic [DELAY_W-1:0] delay_acc;

  logic               any_change_next;
  logic [COL_W-1:0]   box_min_x_next;
  logic [COL_W-1:0]   box_max_x_next;
  logic [ROW_W-1:0]   box_min_y_next;
  logic [ROW_W-1:0]   box_max_y_next;
  logic [DELAY_W:0]   delay_sum;
  logic [DELAY_W-1:0] delay_next;
  logic               diff;

  assign diff = have_previous && (stored != item.pix);

  always_comb begin
    any_change_next = any_change;
    box_min_x_next  = box_min_x;
    box_max_x_next  = box_max_x;
    box_min_y_next  = box_min_y;
    box_max_y_next  = box_max_y;
    if (diff) begin
      any_change_next = 1'b1;
      if (!any_change) begin
        box_min_x_next = item.col;
        box_max_x_next = item.col;
        box_min_y_next = item.row;
        box_max_y_next = item.row;
      end else begin
        if (item.col < box_min_x) box_min_x_next = item.col;
        if (item.col > box_max_x) box_max_x_next = item.col;
        if (item.row < box_min_y) box_min_y_next = item.row;
        if (item.row > box_max_y) box_max_y_next = item.row;
      end
    end
    delay_sum  = {1'b0, delay_acc} + (DELAY_W+1)'(2);
    delay_next = (delay_sum > {1'b0, max_delay}) ? max_delay : delay_sum[DELAY_W-1:0];
  end

  always_comb begin
    res = '0;
    res.delay = delay_next;
    if (!have_previous) begin
      res.changed = 1'b1;
      res.max_x   = last_x;
      res.max_y   = last_y;
      res.first   = 1'b1;
    end else if (any_change_next) begin
      res.changed = 1'b1;
      res.min_x   = COORD_W'(box_min_x_next);
      res.max_x   = COORD_W'(box_max_x_next);
      res.min_y   = COORD_W'(box_min_y_next);
      res.max_y   = COORD_W'(box_max_y_next);
    end
  end

  assign res_valid = fire && item.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_previous <= 1'b0;
      any_change    <= 1'b0;
      box_min_x     <= '1;
      box_max_x     <= '0;
      box_min_y     <= '1;
      box_max_y     <= '0;
      delay_acc     <= '0;
    end else if (fire) begin
      if (item.last) begin
        have_previous <= 1'b1;
        any_change    <= 1'b0;
        box_min_x     <= '1;
        box_max_x     <= '0;
        box_min_y     <= '1;
        box_max_y     <= '0;
        delay_acc     <= (have_previous && any_change_next) ? '0 : delay_next;
      end else begin
        any_change <= any_change_next;
        box_min_x  <= box_min_x_next;
        box_max_x  <= box_max_x_next;
        box_min_y  <= box_min_y_next;
        box_max_y  <= box_max_y_next;
      end
    end
  end

  a_no_change_without_previous: assert property (@(posedge clk) disable iff (rst)
    !have_previous |-> !any_change)
    else $error("change recorded before a previous frame exists");

  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    any_change |-> (box_min_x <= box_max_x) && (box_min_y <= box_max_y))
    else $error("bounding box inverted");

  a_delay_capped: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res.delay <= max_delay)
    else $error("delay above cap");

endmodule
`default_nettype wire

// ===== hdl/frame_change_bounding_box.sv =====
// Top level of the frame change bounding box block: configuration, raster counters,
// frame store read/write and the result register. Depends on fcbb_pkg,
// fcbb_frame_store and fcbb_box_track.
`default_nettype none
// Takes one pixel beat per clock in raster order while input is not stalled and gives one
// result beat per frame; the result register loads when the last pixel of the frame leaves
// the compare stage register. Each pixel costs one read of the frame store when it is taken
// and one write-back when it leaves the compare stage, so the rate is one pixel per clock.
// Input stalls only while a frame result waits in the result register and the next frame
// result is ready behind it. The store holds MAX_WIDTH x MAX_HEIGHT pixels in one RAM and
// needs no clearing pass after reset; the first frame after reset reports the whole frame.
// Write configuration only while idle.
module frame_change_bounding_box
  import fcbb_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DELAY_W-1:0]   cfg_data,
  input  wire logic                 pixel_valid,
  output logic                      pixel_ready,
  input  wire logic [PIX_W-1:0]     pixel_index,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output logic                      changed,
  output logic [COORD_W-1:0]        rect_min_x,
  output logic [COORD_W-1:0]        rect_max_x,
  output logic [COORD_W-1:0]        rect_min_y,
  output logic [COORD_W-1:0]        rect_max_y,
  output logic [DELAY_W-1:0]        delay_out,
  output logic                      first_frame
);

  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [DELAY_W-1:0] max_delay;
  logic [DIM_W-1:0]   w_use;
  logic [DIM_W-1:0]   h_use;

  logic [COL_W-1:0]   col;
  logic [ROW_W-1:0]   row;
  logic               row_end;
  logic               frame_end;
  logic               in_fire;

  logic               s1_valid;
  item_t              s1;
  logic               s1_stall;
  logic               s1_fire;
  logic [PIX_W-1:0]   stored;

  logic               res_valid;
  result_t            res;
  result_t            out_reg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DIM_W'(512);
      frame_height <= DIM_W'(512);
      max_delay    <= '1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_MAX_DELAY:    max_delay    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_use = dim_in_use(frame_width, WIDTH_TOP);
  assign h_use = dim_in_use(frame_height, HEIGHT_TOP);

  assign row_end   = (DIM_W'(col) + DIM_W'(1)) >= w_use;
  assign frame_end = row_end && ((DIM_W'(row) + DIM_W'(1)) >= h_use);

  assign s1_stall    = s1_valid && s1.last && result_valid && !result_ready;
  assign s1_fire     = s1_valid && !s1_stall;
  assign pixel_ready = !s1_stall;
  assign in_fire     = pixel_valid && pixel_ready;

  // advance raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_fire) begin
      if (!row_end) begin
        col <= col + COL_W'(1);
      end else begin
        col <= '0;
        row <= frame_end ? '0 : row + ROW_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1.pix  <= pixel_index;
      s1.col  <= col;
      s1.row  <= row;
      s1.last <= frame_end;
    end
  end

  fcbb_frame_store u_store (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr ({row, col}),
    .rd_data (stored),
    .wr_en   (s1_fire),
    .wr_addr ({s1.row, s1.col}),
    .wr_data (s1.pix)
  );

  fcbb_box_track u_box (
    .clk       (clk),
    .rst       (rst),
    .fire      (s1_fire),
    .item      (s1),
    .stored    (stored),
    .last_x    (COORD_W'(w_use - DIM_W'(1))),
    .last_y    (COORD_W'(h_use - DIM_W'(1))),
    .max_delay (max_delay),
    .res_valid (res_valid),
    .res       (res)
  );

  // hold result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_reg <= res;
    end
  end

  assign changed     = out_reg.changed;
  assign rect_min_x  = out_reg.min_x;
  assign rect_max_x  = out_reg.max_x;
  assign rect_min_y  = out_reg.min_y;
  assign rect_max_y  = out_reg.max_y;
  assign delay_out   = out_reg.delay;
  assign first_frame = out_reg.first;

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(result_valid && !result_ready))
    else $error("result register overwritten");

  a_no_same_entry_overlap: assert property (@(posedge clk) disable iff (rst)
    (in_fire && s1_valid) |-> ({row, col} != {s1.row, s1.col}))
    else $error("read and write-back hit the same store entry");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    s1_stall |=> s1_valid && $stable(s1))
    else $error("stalled compare stage lost its item");

  a_unchanged_box_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !changed) |->
      (rect_min_x == '0) && (rect_max_x == '0) && (rect_min_y == '0) && (rect_max_y == '0))
    else $error("identical frame with nonzero rectangle");

endmodule
`default_nettype wire

// ===== tb/frame_change_bounding_box_tb.sv =====
`timescale 1ns / 100ps
// Testbench for frame_change_bounding_box: random pixel frames against a cycle-free model
// of the bounding box and delay logic, with random idling on both streams.
// Depends on fcbb_pkg and the frame_change_bounding_box RTL.
module frame_change_bounding_box_tb
  import fcbb_pkg::*;
();

  localparam int SETTLE_CYCLES = 8;
  localparam int END_CYCLES    = 24;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_PIXELS = 430;
  localparam int RANDOM_FRAMES = 12;
  localparam int CALM_PIXELS   = 340;

  typedef enum {FRAME_SAME, FRAME_ONE, FRAME_SPARSE, FRAME_FILL, FRAME_NOISE} frame_style_e;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [DELAY_W-1:0]   cfg_data = '0;
  logic                 pixel_valid = 1'b0;
  logic                 pixel_ready;
  logic [PIX_W-1:0]     pixel_index = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic                 changed;
  logic [COORD_W-1:0]   rect_min_x;
  logic [COORD_W-1:0]   rect_max_x;
  logic [COORD_W-1:0]   rect_min_y;
  logic [COORD_W-1:0]   rect_max_y;
  logic [DELAY_W-1:0]   delay_out;
  logic                 first_frame;

  frame_change_bounding_box dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready), .pixel_index(pixel_index),
    .result_valid(result_valid), .result_ready(result_ready),
    .changed(changed), .rect_min_x(rect_min_x), .rect_max_x(rect_max_x),
    .rect_min_y(rect_min_y), .rect_max_y(rect_max_y),
    .delay_out(delay_out), .first_frame(first_frame)
  );

  always #6 clk = ~clk;

  // register copies, shared by stimulus and prediction
  logic [DIM_W-1:0]   width_reg  = DIM_W'(512);
  logic [DIM_W-1:0]   height_reg = DIM_W'(512);
  logic [DELAY_W-1:0] delay_cap  = 16'hFFFF;

  logic [PIX_W-1:0] pending_pixels[$];
  result_t          pending_boxes[$];
  logic [PIX_W-1:0] stream_image [MAX_WIDTH*MAX_HEIGHT];
  logic [PIX_W-1:0] held_image [MAX_WIDTH*MAX_HEIGHT];
  int               gen_col = 0;
  int               gen_row = 0;
  int               pixels_queued = 0;
  bit               calm = 1'b0;
  int               mismatches = 0;
  int               idle_left = 0;
  int               stall_left = 0;
  int               quiet_cycles = 0;

  logic               seen_any;
  logic               box_open;
  logic [COL_W-1:0]   col_at;
  logic [ROW_W-1:0]   row_at;
  logic [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;
  logic [DELAY_W-1:0] delay_acc;

  function automatic int dim_used(input logic [DIM_W-1:0] raw, input int limit);
    int v;
    int ceiling;
    v = int'(raw) & ~1;
    ceiling = limit & ~1;
    if (v < 2) v = 2;
    if (v > ceiling) v = ceiling;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [DELAY_W-1:0] got,
                             input logic [DELAY_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic absorb_pixel(input logic [PIX_W-1:0] pix);
    int      w;
    int      h;
    int      a;
    int      d;
    result_t box;
    w = dim_used(width_reg, MAX_WIDTH);
    h = dim_used(height_reg, MAX_HEIGHT);
    a = int'(row_at) * MAX_WIDTH + int'(col_at);
    if (seen_any && (held_image[a] != pix)) begin
      if (!box_open) begin
        lo_x = col_at;
        hi_x = col_at;
        lo_y = row_at;
        hi_y = row_at;
        box_open = 1'b1;
      end else begin
        if (col_at < lo_x) lo_x = col_at;
        if (col_at > hi_x) hi_x = col_at;
        if (row_at < lo_y) lo_y = row_at;
        if (row_at > hi_y) hi_y = row_at;
      end
    end
    held_image[a] = pix;
    if (int'(col_at) + 1 < w) begin
      col_at = col_at + 1'b1;
    end else begin
      col_at = '0;
      if (int'(row_at) + 1 < h) begin
        row_at = row_at + 1'b1;
      end else begin
        row_at = '0;
        d = int'(delay_acc) + 2;
        if (d > int'(delay_cap)) d = int'(delay_cap);
        delay_acc = DELAY_W'(d);
        box = '0;
        box.delay = delay_acc;
        if (!seen_any) begin
          box.changed = 1'b1;
          box.max_x = COORD_W'(w - 1);
          box.max_y = COORD_W'(h - 1);
          box.first = 1'b1;
          seen_any = 1'b1;
        end else if (box_open) begin
          box.changed = 1'b1;
          box.min_x = lo_x;
          box.max_x = hi_x;
          box.min_y = lo_y;
          box.max_y = hi_y;
          delay_acc = '0;
        end
        pending_boxes.push_back(box);
        box_open = 1'b0;
        lo_x = '1;
        hi_x = '0;
        lo_y = '1;
        hi_y = '0;
      end
    end
  endtask

  // queue count pixels, or up to the end of the frame when count is zero
  task automatic queue_run(input frame_style_e style, input int count, input int spot,
                           input logic [PIX_W-1:0] fill);
    int               k;
    int               a;
    logic [PIX_W-1:0] old;
    logic [PIX_W-1:0] v;
    k = 0;
    do begin
      a = gen_row * MAX_WIDTH + gen_col;
      old = stream_image[a];
      case (style)
        FRAME_SAME:   v = old;
        FRAME_ONE:    v = (k == spot) ? ~old : old;
        FRAME_SPARSE: v = ($urandom_range(0, 15) == 0) ? old ^ PIX_W'($urandom_range(1, 255)) : old;
        FRAME_FILL:   v = fill;
        default:      v = PIX_W'($urandom);
      endcase
      stream_image[a] = v;
      pending_pixels.push_back(v);
      k++;
      if (gen_col + 1 < dim_used(width_reg, MAX_WIDTH)) begin
        gen_col++;
      end else begin
        gen_col = 0;
        if (gen_row + 1 < dim_used(height_reg, MAX_HEIGHT)) gen_row++;
        else gen_row = 0;
      end
    end while ((count > 0) ? (k < count) : (gen_col != 0 || gen_row != 0));
    pixels_queued += k;
  endtask

  task automatic wait_quiet();
    while (pending_pixels.size() != 0 || pixel_valid || pending_boxes.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  width_reg = data[DIM_W-1:0];
      REG_FRAME_HEIGHT: height_reg = data[DIM_W-1:0];
      REG_MAX_DELAY:    delay_cap = data;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pixel_valid <= 1'b0;
      idle_left = 0;
    end else if (!pixel_valid || pixel_ready) begin
      if (idle_left > 0) begin
        idle_left--;
        pixel_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        idle_left = $urandom_range(0, 15);
        pixel_valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        pixel_valid <= 1'b1;
        pixel_index <= pending_pixels.pop_front();
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      result_ready <= 1'b0;
      stall_left = 0;
      seen_any = 1'b0;
      box_open = 1'b0;
      col_at = '0;
      row_at = '0;
      lo_x = '1;
      hi_x = '0;
      lo_y = '1;
      hi_y = '0;
      delay_acc = '0;
    end else begin
      if (result_valid && result_ready) begin
        if (pending_boxes.size() == 0) begin
          report_mismatch("result beat with no frame pending");
        end else begin
          want = pending_boxes.pop_front();
          check_field("changed", changed, want.changed);
          check_field("rect_min_x", rect_min_x, want.min_x);
          check_field("rect_max_x", rect_max_x, want.max_x);
          check_field("rect_min_y", rect_min_y, want.min_y);
          check_field("rect_max_y", rect_max_y, want.max_y);
          check_field("delay_out", delay_out, want.delay);
          check_field("first_frame", first_frame, want.first);
        end
      end
      if (pixel_valid && pixel_ready) absorb_pixel(pixel_index);
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles > QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    int               w_now;
    int               h_now;
    int               pick;
    int               sel;
    int               wr;
    int               hr;
    int               start_pixels;
    int               frames_done;
    logic [DELAY_W-1:0] cap;
    frame_style_e     style;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // first frame: an eight column block of rows, then two rows at the widest
    // setting, so later frames only visit positions already stored
    write_reg(REG_FRAME_WIDTH, 16'd9);
    queue_run(FRAME_NOISE, 14 * 8, 0, '0);
    wait_quiet();
    write_reg(REG_FRAME_WIDTH, 16'hFFFF);
    queue_run(FRAME_NOISE, 512 + 100, 0, '0);
    wait_quiet();
    write_reg(REG_FRAME_HEIGHT, 16'd16);
    queue_run(FRAME_NOISE, 0, 0, '0);

    // height below the floor with a single change in the last pixel
    wait_quiet();
    write_reg(REG_FRAME_WIDTH, 16'd9);
    write_reg(REG_FRAME_HEIGHT, 16'd1);
    queue_run(FRAME_ONE, 0, 15, '0);

    // tallest frame in use with a single change in the last row
    wait_quiet();
    write_reg(REG_FRAME_WIDTH, 16'd3);
    write_reg(REG_FRAME_HEIGHT, 16'd17);
    queue_run(FRAME_ONE, 0, 31, '0);

    wait_quiet();
    write_reg(REG_FRAME_WIDTH, 16'd4);
    write_reg(REG_FRAME_HEIGHT, 16'd4);
    queue_run(FRAME_FILL, 0, 0, 8'h00);
    queue_run(FRAME_FILL, 0, 0, 8'hFF);
    queue_run(FRAME_SAME, 0, 0, '0);
    queue_run(FRAME_SPARSE, 0, 0, '0);

    // delay saturation, a cap below the running delay, and a zero cap
    wait_quiet();
    write_reg(REG_FRAME_WIDTH, 16'd2);
    write_reg(REG_FRAME_HEIGHT, 16'd1);
    write_reg(REG_MAX_DELAY, 16'd5);
    repeat (4) queue_run(FRAME_SAME, 0, 0, '0);
    wait_quiet();
    write_reg(REG_MAX_DELAY, 16'd3);
    queue_run(FRAME_SAME, 0, 0, '0);
    wait_quiet();
    write_reg(REG_MAX_DELAY, 16'd0);
    queue_run(FRAME_SAME, 0, 0, '0);
    queue_run(FRAME_ONE, 0, 2, '0);
    wait_quiet();
    write_reg(REG_MAX_DELAY, 16'hFFFF);

    // shrink width past the current column, then height past the current row
    write_reg(REG_FRAME_WIDTH, 16'd8);
    write_reg(REG_FRAME_HEIGHT, 16'd16);
    queue_run(FRAME_SPARSE, 3 * 8 + 6, 0, '0);
    wait_quiet();
    write_reg(REG_FRAME_WIDTH, 16'd4);
    queue_run(FRAME_SPARSE, 10, 0, '0);
    wait_quiet();
    write_reg(REG_FRAME_HEIGHT, 16'd4);
    queue_run(FRAME_NOISE, 0, 0, '0);

    start_pixels = pixels_queued;
    frames_done = 0;
    while (pixels_queued - start_pixels < RANDOM_PIXELS || frames_done < RANDOM_FRAMES) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_quiet();
        sel = $urandom_range(0, 19);
        if (sel < 12) begin
          wr = $urandom_range(0, 9);
          hr = $urandom_range(0, 9);
        end else if (sel < 16) begin
          wr = $urandom_range(0, 3);
          hr = $urandom_range(0, 17);
        end else begin
          wr = $urandom_range(0, 9);
          hr = $urandom_range(0, 17);
        end
        write_reg(REG_FRAME_WIDTH, {6'($urandom), DIM_W'(wr)});
        write_reg(REG_FRAME_HEIGHT, {6'($urandom), DIM_W'(hr)});
        if ($urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 4))
            0:       cap = '0;
            1:       cap = 16'hFFFF;
            2:       cap = DELAY_W'($urandom_range(1, 12));
            default: cap = DELAY_W'($urandom);
          endcase
          write_reg(REG_MAX_DELAY, cap);
        end
      end
      w_now = dim_used(width_reg, MAX_WIDTH);
      h_now = dim_used(height_reg, MAX_HEIGHT);
      pick = $urandom_range(0, 19);
      if (pick < 4) style = FRAME_SAME;
      else if (pick < 8) style = FRAME_ONE;
      else if (pick < 15) style = FRAME_SPARSE;
      else if (pick < 17) style = FRAME_FILL;
      else style = FRAME_NOISE;
      queue_run(style, 0, $urandom_range(0, w_now * h_now - 1), PIX_W'($urandom));
      frames_done++;
      if (pixels_queued - start_pixels >= CALM_PIXELS) calm = 1'b1;
      while (pending_pixels.size() > 32) @(posedge clk);
    end

    wait_quiet();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
